[hw/rtl/svalloc_pkg.sv]
// Shared types and constants for the voice allocator.
`default_nettype none

package svalloc_pkg;

  localparam int NumVoicesDef = 8;
  localparam int MaxVoices    = 64;
  localparam int VoiceIdxW    = 6;
  localparam int NoteW        = 7;
  localparam int StampW       = 31;

  localparam logic [StampW-1:0] IntMax = {StampW{1'b1}};

  typedef enum logic [1:0] {
    CmdNoteOn  = 2'd0,
    CmdNoteOff = 2'd1,
    CmdFinish  = 2'd2,
    CmdUnused  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StIgnored  = 3'd0,
    StStarted  = 3'd1,
    StStolen   = 3'd2,
    StRelease  = 3'd3,
    StNotFound = 3'd4,
    StCleared  = 3'd5
  } status_e;

  // search beat travelling down the cell chain
  typedef struct packed {
    logic                 valid;
    logic                 free_found;
    logic [VoiceIdxW-1:0] free_idx;
    logic [StampW-1:0]    min_stamp;
    logic [VoiceIdxW-1:0] min_idx;
    logic                 hit_found;
    logic [VoiceIdxW-1:0] hit_idx;
    logic [NoteW-1:0]     fin_note;
  } scan_t;

  // lookup key broadcast to all cells
  typedef struct packed {
    logic [NoteW-1:0]     note;
    logic [VoiceIdxW-1:0] fin;
  } key_t;

  // state update broadcast to all cells
  typedef struct packed {
    logic                 set;
    logic                 clr;
    logic [VoiceIdxW-1:0] idx;
    logic [NoteW-1:0]     note;
    logic [StampW-1:0]    stamp;
  } cell_wr_t;

endpackage

`default_nettype wire

[hw/rtl/svalloc_cell.sv]
// One voice cell: holds a voice's state and folds it into the passing search beat.
`default_nettype none

module svalloc_cell #(
  parameter int CellIdx = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire svalloc_pkg::key_t     key_i,
  input  wire svalloc_pkg::cell_wr_t wr_i,
  input  wire svalloc_pkg::scan_t    pkt_i,
  output svalloc_pkg::scan_t         pkt_o
);
  import svalloc_pkg::*;

  localparam logic [VoiceIdxW-1:0] Idx = VoiceIdxW'(CellIdx);

  logic              active_q;
  logic [NoteW-1:0]  note_q;
  logic [StampW-1:0] stamp_q;
  scan_t             pkt_d, pkt_q;

  always_comb begin
    pkt_d = pkt_i;
    if (!pkt_i.free_found && !active_q) begin
      pkt_d.free_found = 1'b1;
      pkt_d.free_idx   = Idx;
    end
    if (stamp_q < pkt_i.min_stamp) begin
      pkt_d.min_stamp = stamp_q;
      pkt_d.min_idx   = Idx;
    end
    if (!pkt_i.hit_found && active_q && (note_q == key_i.note)) begin
      pkt_d.hit_found = 1'b1;
      pkt_d.hit_idx   = Idx;
    end
    if (key_i.fin == Idx) begin
      pkt_d.fin_note = note_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      note_q   <= '0;
      stamp_q  <= '0;
      pkt_q    <= '0;
    end else begin
      pkt_q <= pkt_d;
      if (wr_i.set && (wr_i.idx == Idx)) begin
        active_q <= 1'b1;
        note_q   <= wr_i.note;
        stamp_q  <= wr_i.stamp;
      end else if (wr_i.clr && (wr_i.idx == Idx)) begin
        active_q <= 1'b0;
      end
    end
  end

  assign pkt_o = pkt_q;

endmodule

`default_nettype wire

[hw/rtl/synth_voice_allocator.sv]
// Top level of the polyphonic voice allocator with oldest-voice stealing.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------------
//   in      | input     | in_valid_i / in_stall_o   | command, note, velocity,
//           |           |                           | timestamp, finished_voice
//   out     | output    | out_valid_o / out_stall_i | status, voice, note_out, velocity_out
//
// One beat at a time: a search beat walks the cell chain, one cell per cycle, and the
// next item is accepted only once the result of the last one has been committed.
// The result register frees the input side: the next item is accepted while a result waits.
// A scan that ends while the result register is still stalled waits before committing.
// Reset clears all voices to inactive with note and stamp zero; no clearing pass.
`default_nettype none

module synth_voice_allocator #(
  parameter int NumVoices = svalloc_pkg::NumVoicesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [6:0]  note_i,
  input  wire logic [6:0]  velocity_i,
  input  wire logic [30:0] timestamp_i,
  input  wire logic [2:0]  finished_voice_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [2:0]       voice_o,
  output logic [6:0]       note_out_o,
  output logic [6:0]       velocity_out_o
);
  import svalloc_pkg::*;

  typedef enum logic [1:0] {
    StateIdle,
    StateScan,
    StateDone
  } state_e;

  state_e            state_q;
  logic              start_q;
  cmd_e              cmd_q;
  logic [NoteW-1:0]  note_q;
  logic [6:0]        vel_q;
  logic [StampW-1:0] ts_q;
  logic [2:0]        fin_q;
  scan_t             res_pkt_q;
  logic              out_valid_q;
  status_e           status_q;
  logic [2:0]        voice_q;
  logic [6:0]        note_out_q;
  logic [6:0]        vel_out_q;

  scan_t             chain [NumVoices+1];
  logic [NumVoices:0] chain_valid;
  key_t              key;
  cell_wr_t          cell_wr;
  logic              accept, commit;
  status_e           res_status;
  logic [VoiceIdxW-1:0] res_voice;
  logic [6:0]        res_note, res_vel;
  logic [VoiceIdxW-1:0] pick;

  assign accept = in_valid_i && !in_stall_o;
  assign commit = (state_q == StateDone) && (!out_valid_q || !out_stall_i);

  assign key.note = note_q;
  assign key.fin  = VoiceIdxW'(fin_q);

  always_comb begin
    chain[0]            = '0;
    chain[0].valid      = start_q;
    chain[0].min_stamp  = IntMax;
  end

  for (genvar g = 0; g < NumVoices; g++) begin : g_cell
    svalloc_cell #(
      .CellIdx(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .key_i (key),
      .wr_i  (cell_wr),
      .pkt_i (chain[g]),
      .pkt_o (chain[g+1])
    );
  end

  for (genvar g = 0; g <= NumVoices; g++) begin : g_vld
    assign chain_valid[g] = chain[g].valid;
  end

  always_comb begin
    res_status = StIgnored;
    res_voice  = '0;
    res_note   = '0;
    res_vel    = '0;
    pick       = res_pkt_q.free_found ? res_pkt_q.free_idx : res_pkt_q.min_idx;
    cell_wr    = '0;
    case (cmd_q)
      CmdNoteOn: begin
        if (vel_q != '0) begin
          res_status = res_pkt_q.free_found ? StStarted : StStolen;
          res_voice  = pick;
          res_note   = note_q;
          res_vel    = vel_q;
          cell_wr.set   = commit;
          cell_wr.idx   = pick;
          cell_wr.note  = note_q;
          cell_wr.stamp = ts_q;
        end
      end
      CmdNoteOff: begin
        res_note = note_q;
        if (res_pkt_q.hit_found) begin
          res_status = StRelease;
          res_voice  = res_pkt_q.hit_idx;
        end else begin
          res_status = StNotFound;
        end
      end
      CmdFinish: begin
        if (32'(fin_q) < NumVoices) begin
          res_status  = StCleared;
          res_voice   = VoiceIdxW'(fin_q);
          res_note    = res_pkt_q.fin_note;
          cell_wr.clr = commit;
          cell_wr.idx = VoiceIdxW'(fin_q);
        end
      end
      default: begin
        res_status = StIgnored;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateIdle;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      cmd_q       <= CmdNoteOn;
      status_q    <= StIgnored;
      note_q      <= '0;
      vel_q       <= '0;
      ts_q        <= '0;
      fin_q       <= '0;
      res_pkt_q   <= '0;
      voice_q     <= '0;
      note_out_q  <= '0;
      vel_out_q   <= '0;
    end else begin
      start_q <= accept;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StateIdle: begin
          if (accept) begin
            cmd_q   <= cmd_e'(command_i);
            note_q  <= note_i;
            vel_q   <= velocity_i;
            ts_q    <= timestamp_i;
            fin_q   <= finished_voice_i;
            state_q <= StateScan;
          end
        end
        StateScan: begin
          if (chain[NumVoices].valid) begin
            res_pkt_q <= chain[NumVoices];
            state_q   <= StateDone;
          end
        end
        StateDone: begin
          if (commit) begin
            status_q    <= res_status;
            voice_q     <= res_voice[2:0];
            note_out_q  <= res_note;
            vel_out_q   <= res_vel;
            state_q     <= StateIdle;
          end
        end
        default: begin
          state_q <= StateIdle;
        end
      endcase
    end
  end

  assign in_stall_o     = (state_q != StateIdle);
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign voice_o        = voice_q;
  assign note_out_o     = note_out_q;
  assign velocity_out_o = vel_out_q;

  a_one_beat_in_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain_valid))
    else $error("more than one search beat in the cell chain");

  a_chain_end_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[NumVoices].valid |-> (state_q == StateScan))
    else $error("search beat left the chain outside a scan");

  a_write_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_wr.set || cell_wr.clr) |-> commit)
    else $error("voice state written outside commit");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StateDone))
    else $error("result raised without a finished scan");

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for synth_voice_allocator: directed and random voice events.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import svalloc_pkg::*;

  localparam int NumVoices = NumVoicesDef;
  localparam int Latency   = NumVoices + 2;

  typedef struct packed {
    status_e    status;
    logic [2:0] voice;
    logic [6:0] note;
    logic [6:0] velocity;
  } voice_event_t;

  typedef enum int {
    StallNone,
    StallLight,
    StallHeavy,
    StallRuns
  } stall_mode_e;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  cmd_e        ev_command  = CmdNoteOn;
  logic [6:0]  ev_note     = '0;
  logic [6:0]  ev_velocity = '0;
  logic [30:0] ev_stamp    = '0;
  logic [2:0]  ev_fin      = '0;
  logic        res_valid;
  logic        res_stall   = 1'b0;
  logic [2:0]  res_status;
  logic [2:0]  res_voice;
  logic [6:0]  res_note;
  logic [6:0]  res_velocity;

  // voice table as the allocator should hold it
  logic [NoteW-1:0]  held_note   [NumVoices];
  logic [StampW-1:0] start_stamp [NumVoices];
  logic              voice_busy  [NumVoices];

  voice_event_t pending_events[$];
  int           mismatches  = 0;
  int           gap_max     = 0;
  int           burst_left  = 1;
  logic [30:0]  stamp_clock = '0;

  stall_mode_e  stall_mode  = StallNone;
  int           mode_left   = 0;
  int           run_left    = 0;
  logic         run_high    = 1'b0;

  synth_voice_allocator DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .command_i        (ev_command),
    .note_i           (ev_note),
    .velocity_i       (ev_velocity),
    .timestamp_i      (ev_stamp),
    .finished_voice_i (ev_fin),
    .out_valid_o      (res_valid),
    .out_stall_i      (res_stall),
    .status_o         (res_status),
    .voice_o          (res_voice),
    .note_out_o       (res_note),
    .velocity_out_o   (res_velocity)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic voice_event_t allocate_voice(cmd_e cmd, logic [6:0] note,
                                                  logic [6:0] vel, logic [30:0] stamp,
                                                  logic [2:0] fin);
    voice_event_t ev;
    int           pick;
    bit           free_hit;
    bit           hit;
    ev.status   = StIgnored;
    ev.voice    = '0;
    ev.note     = '0;
    ev.velocity = '0;
    pick        = 0;
    free_hit    = 1'b0;
    hit         = 1'b0;
    case (cmd)
      CmdNoteOn: begin
        if (vel != '0) begin
          for (int i = 0; i < NumVoices; i++) begin
            if (!free_hit && !voice_busy[i]) begin
              pick     = i;
              free_hit = 1'b1;
            end
          end
          // oldest stamp loses its voice, lowest index on ties
          if (!free_hit) begin
            for (int i = 1; i < NumVoices; i++) begin
              if (start_stamp[i] < start_stamp[pick]) pick = i;
            end
          end
          held_note[pick]   = note;
          start_stamp[pick] = stamp;
          voice_busy[pick]  = 1'b1;
          if (free_hit) ev.status = StStarted;
          else ev.status = StStolen;
          ev.voice    = pick[2:0];
          ev.note     = note;
          ev.velocity = vel;
        end
      end
      CmdNoteOff: begin
        for (int i = 0; i < NumVoices; i++) begin
          if (!hit && voice_busy[i] && held_note[i] == note) begin
            hit      = 1'b1;
            ev.voice = 3'(i);
          end
        end
        if (hit) ev.status = StRelease;
        else ev.status = StNotFound;
        ev.note = note;
      end
      CmdFinish: begin
        if (int'(fin) < NumVoices) begin
          voice_busy[fin] = 1'b0;
          ev.status       = StCleared;
          ev.voice        = fin;
          ev.note         = held_note[fin];
        end
      end
      default: begin
      end
    endcase
    return ev;
  endfunction

  function automatic logic [30:0] pick_stamp();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return IntMax;
    if (r < 4) return 31'($urandom_range(0, 3));
    if (r < 7) begin
      stamp_clock = stamp_clock + 31'($urandom_range(0, 50));
      return stamp_clock;
    end
    return 31'($urandom());
  endfunction

  function automatic logic [6:0] pick_note();
    if ($urandom_range(0, 2) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(0, 11));
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    if (mismatches < 50)
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  task automatic send_event(cmd_e c, logic [6:0] n, logic [6:0] v, logic [30:0] ts,
                            logic [2:0] f);
    int           gap;
    voice_event_t exp_ev;
    @(negedge clk);
    in_valid    <= 1'b1;
    ev_command  <= c;
    ev_note     <= n;
    ev_velocity <= v;
    ev_stamp    <= ts;
    ev_fin      <= f;
    do @(posedge clk); while (in_stall);
    exp_ev = allocate_voice(c, n, v, ts, f);
    pending_events.insert(pending_events.size(), exp_ev);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(0, gap_max);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic drain_pending();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    gap_max = 0;
    send_event(CmdNoteOn, 7'd127, 7'd0, IntMax, 3'd7);
    send_event(CmdUnused, 7'd127, 7'd127, IntMax, 3'd7);
    send_event(CmdNoteOff, 7'd64, 7'd127, 31'd0, 3'd0);
    send_event(CmdFinish, 7'd0, 7'd0, 31'd0, 3'd3);
    for (int i = 0; i < NumVoices; i++)
      send_event(CmdNoteOn, (i == 1) ? 7'd127 : 7'(i * 17), 7'(i * 18 + 1), IntMax, 3'(i));
    // all stamps equal: voice 0 goes first
    send_event(CmdNoteOn, 7'd60, 7'd127, IntMax, 3'd0);
    send_event(CmdNoteOn, 7'd61, 7'd1, 31'd0, 3'd5);
    send_event(CmdNoteOn, 7'd62, 7'd5, 31'd100, 3'd2);
    send_event(CmdNoteOff, 7'd127, 7'd0, 31'd0, 3'd0);
    send_event(CmdNoteOff, 7'd0, 7'd0, 31'd0, 3'd0);
    send_event(CmdFinish, 7'd0, 7'd0, 31'd0, 3'd7);
    send_event(CmdFinish, 7'd0, 7'd0, 31'd0, 3'd7);
    send_event(CmdNoteOn, 7'd33, 7'd64, 31'd5, 3'd1);
    send_event(CmdFinish, 7'd0, 7'd0, 31'd0, 3'd0);
    send_event(CmdNoteOff, 7'd62, 7'd0, 31'd0, 3'd0);
    send_event(CmdFinish, 7'd127, 7'd127, IntMax, 3'd1);
    send_event(CmdNoteOff, 7'd127, 7'd0, 31'd0, 3'd0);
    drain_pending();
  endtask

  task automatic test_steal_heavy(int count);
    gap_max = 2;
    repeat (count) begin
      if ($urandom_range(0, 19) < 17)
        send_event(CmdNoteOn, pick_note(), 7'($urandom_range(1, 127)), pick_stamp(),
                   3'($urandom_range(0, 7)));
      else
        send_event(CmdFinish, pick_note(), 7'($urandom_range(0, 127)), pick_stamp(),
                   3'($urandom_range(0, 7)));
    end
    drain_pending();
  endtask

  task automatic test_release_flow(int count);
    int sent;
    int v;
    sent    = 0;
    gap_max = 5;
    while (sent < count) begin
      v = $urandom_range(0, NumVoices - 1);
      if (voice_busy[v] && $urandom_range(0, 2) != 0) begin
        send_event(CmdNoteOff, held_note[v], 7'($urandom_range(0, 127)), pick_stamp(),
                   3'($urandom_range(0, 7)));
        send_event(CmdFinish, pick_note(), 7'($urandom_range(0, 127)), pick_stamp(), 3'(v));
        sent += 2;
      end else begin
        send_event(CmdNoteOn, pick_note(), 7'($urandom_range(1, 127)), pick_stamp(),
                   3'($urandom_range(0, 7)));
        sent++;
      end
    end
    drain_pending();
  endtask

  task automatic test_mixed_noise(int count);
    int         r;
    cmd_e       c;
    logic [6:0] vel;
    gap_max = 12;
    repeat (count) begin
      r = $urandom_range(0, 19);
      if (r < 9) c = CmdNoteOn;
      else if (r < 14) c = CmdNoteOff;
      else if (r < 19) c = CmdFinish;
      else c = CmdUnused;
      vel = ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(0, 127));
      send_event(c, pick_note(), vel, pick_stamp(), 3'($urandom_range(0, 7)));
    end
    drain_pending();
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(50, 400);
    end
    mode_left--;
    case (stall_mode)
      StallNone:  res_stall <= 1'b0;
      StallLight: res_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy: res_stall <= ($urandom_range(0, 1) == 0);
      default: begin
        if (run_left == 0) begin
          run_high = !run_high;
          run_left = run_high ? $urandom_range(1, 30) : $urandom_range(1, 8);
        end
        run_left--;
        res_stall <= run_high;
      end
    endcase
  end

  always @(posedge clk) begin : check_result
    voice_event_t want;
    if (rst_n && res_valid && !res_stall) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected beat, status", 0, res_status);
      end else begin
        want = pending_events.pop_front();
        if (res_status != want.status) report_mismatch("status", want.status, res_status);
        if (res_voice != want.voice) report_mismatch("voice", want.voice, res_voice);
        if (res_note != want.note) report_mismatch("note_out", want.note, res_note);
        if (res_velocity != want.velocity)
          report_mismatch("velocity_out", want.velocity, res_velocity);
      end
    end
  end

  initial begin
    for (int i = 0; i < NumVoices; i++) begin
      held_note[i]   = '0;
      start_stamp[i] = '0;
      voice_busy[i]  = 1'b0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_steal_heavy(500);
    test_release_flow(450);
    test_mixed_noise(880);
    repeat (3 * Latency) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
